### src/mi_pkg.sv
// Shared types and constants for the modular inverse core.
// Transaction payloads, datapath lane, sequencer state, step opcodes and control structs.
// No dependencies.
package mi_pkg;

   // Field widths of a transaction
   localparam int VALUE_W = 32;
   localparam int MOD_W   = VALUE_W - 1;
   // Bezout coefficients carry headroom above the operand width
   localparam int COEF_W  = VALUE_W + 3;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic        [MOD_W-1:0]   modulus;
   } mi_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] inverse_value;
      logic                      exists;
   } mi_rsp_type;

   // One working lane: remainder and its two coefficients,
   // with s * x + t * y == r held through the halve and subtract steps
   typedef struct packed {
      logic        [VALUE_W-1:0] r;
      logic signed [COEF_W-1:0]  s;
      logic signed [COEF_W-1:0]  t;
   } mi_lane_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIX,
      ST_DONE
   } mi_state_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_HALVE,
      OP_SUB,
      OP_ADDN,
      OP_SUBN
   } mi_op_type;

   // Conditions seen by the sequencer
   typedef struct packed {
      logic input_ok;
      logic u_zero;
      logic u_even;
      logic v_even;
      logic u_ge_v;
      logic v_one;
      logic c_neg;
      logic c_ge_n;
   } mi_status_type;

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic      load;
      mi_op_type op;
      logic      a_is_v;
      logic      write_u;
      logic      write_v;
      logic      capture_zero;
      logic      capture_coef;
      logic      req_stall;
      logic      rsp_valid;
   } mi_ctrl_type;

endpackage

### src/mi_step_unit.sv
// Shared step unit of the binary extended GCD: halve, subtract, or adjust by the modulus.
// Two lanes in, one lane out, purely combinational.
// Depends on mi_pkg.
module mi_step_unit (
   input  mi_pkg::mi_op_type                op,
   input  mi_pkg::mi_lane_type              a,
   input  mi_pkg::mi_lane_type              b,
   input  logic [mi_pkg::VALUE_W-1:0]       x,
   input  logic [mi_pkg::MOD_W-1:0]         y,
   output mi_pkg::mi_lane_type              result
);
   import mi_pkg::*;

   logic signed [COEF_W-1:0] x_ext;
   logic signed [COEF_W-1:0] y_ext;
   logic signed [COEF_W-1:0] s_opnd;
   logic signed [COEF_W-1:0] t_opnd;
   logic signed [COEF_W-1:0] s_sum;
   logic signed [COEF_W-1:0] t_sum;
   logic        [VALUE_W-1:0] r_diff;

   assign x_ext = $signed({{(COEF_W-VALUE_W){1'b0}}, x});
   assign y_ext = $signed({{(COEF_W-MOD_W){1'b0}}, y});

   // Pick the addends for the two coefficient adders
   always_comb begin
      s_opnd = '0;
      t_opnd = '0;
      case (op)
         OP_HALVE: begin
            if (a.s[0] | a.t[0]) begin
               s_opnd = y_ext;
               t_opnd = -x_ext;
            end
         end
         OP_SUB: begin
            s_opnd = -b.s;
            t_opnd = -b.t;
         end
         OP_ADDN: s_opnd = y_ext;
         OP_SUBN: s_opnd = -y_ext;
         default: begin
            s_opnd = '0;
            t_opnd = '0;
         end
      endcase
   end

   assign s_sum  = a.s + s_opnd;
   assign t_sum  = a.t + t_opnd;
   assign r_diff = a.r - b.r;

   // Form the new lane
   always_comb begin
      result = a;
      case (op)
         OP_HALVE: begin
            result.r = a.r >> 1;
            result.s = s_sum >>> 1;
            result.t = t_sum >>> 1;
         end
         OP_SUB: begin
            result.r = r_diff;
            result.s = s_sum;
            result.t = t_sum;
         end
         OP_ADDN, OP_SUBN: result.s = s_sum;
         default: result = a;
      endcase
   end

endmodule

### src/mi_sequencer.sv
// Sequencer of the modular inverse core: accept, iterate the step unit, correct, deliver.
// Drives the datapath through a control struct.
// Depends on mi_pkg.
module mi_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 rsp_stall,
   input  mi_pkg::mi_status_type status,
   output mi_pkg::mi_ctrl_type   ctrl
);
   import mi_pkg::*;

   mi_state_type state_ff;
   mi_state_type state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance the state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.input_ok ? ST_RUN : ST_DONE;
            end
         end
         ST_RUN: begin
            if (status.u_zero) begin
               state_in = status.v_one ? ST_FIX : ST_DONE;
            end
         end
         ST_FIX: begin
            if (!status.c_neg && !status.c_ge_n) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Drive the datapath
   always_comb begin
      ctrl = '0;
      ctrl.op = OP_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               ctrl.capture_zero = !status.input_ok;
            end
         end
         ST_RUN: begin
            ctrl.req_stall = 1'b1;
            if (status.u_zero) begin
               ctrl.capture_zero = !status.v_one;
            end else if (status.u_even) begin
               ctrl.op = OP_HALVE;
               ctrl.write_u = 1'b1;
            end else if (status.v_even) begin
               ctrl.op = OP_HALVE;
               ctrl.a_is_v = 1'b1;
               ctrl.write_v = 1'b1;
            end else if (status.u_ge_v) begin
               ctrl.op = OP_SUB;
               ctrl.write_u = 1'b1;
            end else begin
               ctrl.op = OP_SUB;
               ctrl.a_is_v = 1'b1;
               ctrl.write_v = 1'b1;
            end
         end
         ST_FIX: begin
            ctrl.req_stall = 1'b1;
            ctrl.a_is_v = 1'b1;
            if (status.c_neg) begin
               ctrl.op = OP_ADDN;
               ctrl.write_v = 1'b1;
            end else if (status.c_ge_n) begin
               ctrl.op = OP_SUBN;
               ctrl.write_v = 1'b1;
            end else begin
               ctrl.capture_coef = 1'b1;
            end
         end
         ST_DONE: begin
            ctrl.req_stall = 1'b1;
            ctrl.rsp_valid = 1'b1;
         end
         default: ctrl.req_stall = 1'b1;
      endcase
   end

endmodule

### src/modular_inverse_core.sv
// Top level of the modular inverse core: lane registers, operand registers, result register.
// Instantiates mi_step_unit and mi_sequencer; depends on mi_pkg.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  mi_req_type  (value, modulus)
//   rsp       out         rsp_valid / rsp_stall  mi_rsp_type  (inverse_value, exists)
//
// Flow: one transaction at a time through one shared step unit (halve, subtract or
//   add/subtract modulus per cycle). An item is accepted and loaded, iterated through the
//   step unit until the remainder of u reaches zero, brought into the modulus range when
//   an inverse exists, then held in the result register until taken. Rejected inputs
//   (modulus below 2, zero value, both even) go straight to the result register.
// Reset: returns the sequencer to idle and keeps req_stall high while reset is high;
//   no storage needs clearing.
// Stalls: req_stall stays high from acceptance until the result is taken; the result
//   register holds while rsp_stall is high.
module modular_inverse_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mi_pkg::mi_req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mi_pkg::mi_rsp_type rsp_payload
);
   import mi_pkg::*;

   mi_lane_type          u_ff;
   mi_lane_type          v_ff;
   logic [VALUE_W-1:0]   x_ff;
   logic [MOD_W-1:0]     y_ff;
   logic                 neg_ff;
   mi_rsp_type           rsp_ff;

   mi_lane_type          u_in;
   mi_lane_type          v_in;
   mi_lane_type          lane_a;
   mi_lane_type          lane_b;
   mi_lane_type          step_out;
   mi_status_type        status;
   mi_ctrl_type          ctrl;

   logic [VALUE_W-1:0]   value_bits;
   logic [VALUE_W-1:0]   mag;
   logic                 value_neg;
   logic signed [COEF_W-1:0] y_ext;
   logic [VALUE_W-1:0]   coef_low;

   // Magnitude of the incoming value; the most negative value maps to 2^(VALUE_W-1)
   assign value_bits = req_payload.value;
   assign value_neg  = value_bits[VALUE_W-1];
   assign mag        = value_neg ? (~value_bits + 1'b1) : value_bits;
   assign y_ext      = $signed({{(COEF_W-MOD_W){1'b0}}, y_ff});

   // Status for the sequencer
   always_comb begin
      status.input_ok = (req_payload.modulus > MOD_W'(1)) && (mag != '0)
                        && (mag[0] | req_payload.modulus[0]);
      status.u_zero   = (u_ff.r == '0);
      status.u_even   = !u_ff.r[0];
      status.v_even   = !v_ff.r[0];
      status.u_ge_v   = (u_ff.r >= v_ff.r);
      status.v_one    = (v_ff.r == VALUE_W'(1));
      status.c_neg    = v_ff.s[COEF_W-1];
      status.c_ge_n   = (v_ff.s >= y_ext);
   end

   mi_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   // Route lanes into the shared step unit
   assign lane_a = ctrl.a_is_v ? v_ff : u_ff;
   assign lane_b = ctrl.a_is_v ? u_ff : v_ff;

   mi_step_unit u_step (
      .op     (ctrl.op),
      .a      (lane_a),
      .b      (lane_b),
      .x      (x_ff),
      .y      (y_ff),
      .result (step_out)
   );

   // Select next lane contents: load on accept, else write back the step result
   always_comb begin
      u_in = u_ff;
      v_in = v_ff;
      if (ctrl.load) begin
         u_in.r = mag;
         u_in.s = COEF_W'(1);
         u_in.t = '0;
         v_in.r = {{(VALUE_W-MOD_W){1'b0}}, req_payload.modulus};
         v_in.s = '0;
         v_in.t = COEF_W'(1);
      end else if (ctrl.write_u) begin
         u_in = step_out;
      end else if (ctrl.write_v) begin
         v_in = step_out;
      end
   end

   // Hold lanes and operands
   always_ff @(posedge clock) begin
      u_ff <= u_in;
      v_ff <= v_in;
      if (ctrl.load) begin
         x_ff   <= mag;
         y_ff   <= req_payload.modulus;
         neg_ff <= value_neg;
      end
   end

   // Capture the result transaction
   assign coef_low = v_ff.s[VALUE_W-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.capture_zero) begin
         rsp_ff.inverse_value <= '0;
         rsp_ff.exists        <= 1'b0;
      end else if (ctrl.capture_coef) begin
         rsp_ff.inverse_value <= neg_ff ? (~coef_low + 1'b1) : coef_low;
         rsp_ff.exists        <= 1'b1;
      end
   end

   // Keep the input closed while reset is high
   assign req_stall   = ctrl.req_stall | reset;
   assign rsp_valid   = ctrl.rsp_valid;
   assign rsp_payload = rsp_ff;

   // A result on offer means no new transaction can enter
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("result offered while input open");

   // An accepted transaction closes the input on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input still open after acceptance");

   // A found inverse is never zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.exists) |-> (rsp_payload.inverse_value != '0))
      else $error("inverse flagged but zero");

   // No inverse means a zero value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.exists) |-> (rsp_payload.inverse_value == '0))
      else $error("missing inverse with nonzero value");

endmodule

### dv/tb_modular_inverse_core.sv
// Self-checking testbench for modular_inverse_core: directed corner cases, then random
// value/modulus pairs under three sender/receiver stall mixes. Needs mi_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_modular_inverse_core;
   import mi_pkg::*;

   localparam int unsigned IDLE_LIMIT  = 5000;  // cycles with no transaction on either side
   localparam int unsigned RANDOM_ITEMS = 145;  // per stall phase
   localparam int unsigned SETTLE_CYCLES = 150;

   // Expected-result store plus a predictor built on the extended Euclidean algorithm
   class inverse_scoreboard;
      mi_rsp_type  expected_inverses[$];
      int unsigned fail_count;
      int unsigned checked_count;
      int unsigned invertible_count;

      function mi_rsp_type predict_inverse(mi_req_type req);
         longint     magnitude;
         longint     modulus;
         longint     rem_prev;
         longint     rem_cur;
         longint     coef_prev;
         longint     coef_cur;
         longint     quotient;
         longint     scratch;
         bit         negative;
         mi_rsp_type rsp;
         rsp       = '0;
         negative  = req.value[VALUE_W-1];
         magnitude = longint'(req.value);
         if (negative) magnitude = -magnitude;
         modulus   = longint'(req.modulus);
         if (modulus > 1 && magnitude != 0 && (magnitude % modulus) != 0) begin
            rem_prev  = modulus;
            rem_cur   = magnitude % modulus;
            coef_prev = 0;
            coef_cur  = 1;
            // Run Euclid, keeping only the coefficient of the reduced value
            while (rem_cur != 0) begin
               quotient  = rem_prev / rem_cur;
               scratch   = rem_prev - quotient * rem_cur;
               rem_prev  = rem_cur;
               rem_cur   = scratch;
               scratch   = coef_prev - quotient * coef_cur;
               coef_prev = coef_cur;
               coef_cur  = scratch;
            end
            if (rem_prev == 1) begin
               if (coef_prev < 0) coef_prev += modulus;
               rsp.inverse_value = negative ? VALUE_W'(-coef_prev) : VALUE_W'(coef_prev);
               rsp.exists        = 1'b1;
            end
         end
         return rsp;
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $time, what);
         fail_count++;
      endtask

      function int unsigned pending();
         return expected_inverses.size();
      endfunction

      function void note_request(mi_req_type req);
         expected_inverses.push_back(predict_inverse(req));
      endfunction

      task check_result(mi_rsp_type rsp);
         mi_rsp_type want;
         if (expected_inverses.size() == 0) begin
            report($sformatf("result with nothing expected: inverse %0d exists %0b",
                             rsp.inverse_value, rsp.exists));
         end else begin
            want = expected_inverses.pop_front();
            checked_count++;
            if (want.exists) invertible_count++;
            if (rsp.inverse_value !== want.inverse_value)
               report($sformatf("inverse_value got %0d want %0d",
                                rsp.inverse_value, want.inverse_value));
            if (rsp.exists !== want.exists)
               report($sformatf("exists got %0b want %0b", rsp.exists, want.exists));
         end
      endtask
   endclass

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   mi_req_type req_payload = '0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   mi_rsp_type rsp_payload;

   inverse_scoreboard sb;
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned sent_count   = 0;
   int unsigned idle_cycles  = 0;

   modular_inverse_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Check each result transaction, then pick next cycle's stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
      rsp_stall <= (rsp_idle_pct != 0) && ($urandom_range(99) < rsp_idle_pct);
   end

   // End the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] timeout: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("modular_inverse_core regression: fail");
            $finish;
         end
      end
   end

   // Present one request, idling first at the sender's rate; return at its acceptance edge
   task send_request(mi_req_type req);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= req;
      do @(posedge clock); while (req_stall);
      sb.note_request(req);
      sent_count++;
   endtask

   task send_pair(logic signed [VALUE_W-1:0] value, logic [MOD_W-1:0] modulus);
      mi_req_type req;
      req.value   = value;
      req.modulus = modulus;
      send_request(req);
   endtask

   // Hold off the sender until every expected result has been taken
   task wait_for_drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Mix small, power-of-two, odd and full-range moduli with zero, multiples and wide values
   function mi_req_type random_request();
      mi_req_type req;
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick == 0)      req.modulus = MOD_W'($urandom_range(0, 1));
      else if (pick <= 5) req.modulus = MOD_W'($urandom_range(2, 255));
      else if (pick <= 7) req.modulus = MOD_W'(1) << $urandom_range(1, MOD_W - 1);
      else if (pick <= 15) req.modulus = MOD_W'($urandom()) | MOD_W'(1);
      else                req.modulus = MOD_W'($urandom());
      pick = $urandom_range(0, 19);
      if (pick == 0)      req.value = '0;
      else if (pick == 1) req.value = VALUE_W'(req.modulus) * VALUE_W'($urandom_range(1, 3));
      else if (pick == 2) req.value = {1'b1, {(VALUE_W-1){1'b0}}};
      else if (pick <= 7) req.value = VALUE_W'($urandom_range(1, 1000));
      else                req.value = VALUE_W'($urandom());
      if (pick != 2 && $urandom_range(0, 1)) req.value = -req.value;
      return req;
   endfunction

   task run_random_phase(int unsigned sender_pct, int unsigned receiver_pct);
      req_idle_pct = sender_pct;
      rsp_idle_pct = receiver_pct;
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         send_request(random_request());
         if ($urandom_range(0, 39) == 0) wait_for_drain();
      end
      wait_for_drain();
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed corners under the first stall mix
      req_idle_pct = 32;
      rsp_idle_pct = 70;
      send_pair(32'sd0, 31'd7);                  // zero value
      send_pair(32'sd3, 31'd0);                  // modulus zero
      send_pair(32'sd3, 31'd1);                  // modulus one
      send_pair(32'sd1, 31'd2);
      send_pair(-32'sd1, 31'd7);                 // minus one
      send_pair(32'sh7FFF_FFFF, 31'h7FFF_FFFF);  // value equals modulus
      send_pair(32'sh8000_0001, 31'h7FFF_FFFE);  // most negative in range
      send_pair(32'sh8000_0000, 31'h7FFF_FFFF);  // most negative overall
      send_pair(32'sh8000_0000, 31'd3);
      send_pair(32'sd6, 31'd9);                  // common factor
      send_pair(32'sd14, 31'd7);                 // multiple of modulus
      send_pair(32'sd3, 31'h7FFF_FFFF);
      send_pair(32'sh7FFF_FFFE, 31'h7FFF_FFFF);
      send_pair(-32'sd5, 31'd17);
      send_pair(32'sd2, 31'h4000_0000);          // both even
      send_pair(32'sh1234_5679, 31'h7FFF_FFFE);
      send_pair(32'sd5, 31'd2);
      send_pair(32'sd100, 31'd7);                // value above modulus
      send_pair(-32'sd3, 31'd2);
      send_pair(-32'sh7FFF_FFFF, 31'h5555_5555);
      wait_for_drain();

      run_random_phase(32, 70);
      run_random_phase(70, 32);
      run_random_phase(0, 0);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
      $display("covered %0d requests (directed corners plus random pairs, three stall mixes)",
               sent_count);
      $display("checked %0d results, %0d with an inverse, %0d mismatches",
               sb.checked_count, sb.invertible_count, sb.fail_count);
      if (sb.fail_count == 0) begin
         $display("modular_inverse_core regression: pass");
      end else begin
         $display("modular_inverse_core regression: fail");
      end
      $finish;
   end

endmodule

### filelist.f
src/mi_pkg.sv
src/mi_step_unit.sv
src/mi_sequencer.sv
src/modular_inverse_core.sv
dv/tb_modular_inverse_core.sv
